[rtl/core/gasf_pkg.sv]
package gasf_pkg;

  localparam int SCORE_W  = 18;
  localparam int EXT_W    = SCORE_W + 2;
  localparam int BRANCH_W = 17;
  localparam int SYM_W    = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_TOP_LEN_DEF  = 256;
  localparam int MAX_SIDE_LEN_DEF = 256;

  // magnitude of the most negative score
  localparam int unsigned SCORE_MIN_MAG = 131072;

  typedef logic signed [SCORE_W-1:0]  score_t;
  typedef logic signed [EXT_W-1:0]    ext_t;
  typedef logic [BRANCH_W-1:0]        branch_t;

  localparam score_t  ScoreMax  = score_t'(131071);
  localparam score_t  ScoreMin  = score_t'(-131072);
  localparam branch_t BranchMax = '1;

  // item commands
  localparam logic CMD_LOAD_TOP = 1'b0;
  localparam logic CMD_SIDE     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEL    = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] final_score;
    logic [BRANCH_W-1:0]       branch_count;
    logic                      length_overflow;
  } result_t;

  typedef struct packed {
    score_t           diag;
    score_t           up;
    score_t           left;
    logic             is_match;
    logic [CFG_W-1:0] bonus;
    logic [CFG_W-1:0] mismatch;
    logic [CFG_W-1:0] indel;
  } cell_in_t;

  typedef struct packed {
    score_t best;
    logic   branch;
  } cell_out_t;

  function automatic score_t sat_score(input ext_t v);
    score_t r;
    if (v > ext_t'(ScoreMax)) begin
      r = ScoreMax;
    end else if (v < ext_t'(ScoreMin)) begin
      r = ScoreMin;
    end else begin
      r = score_t'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/global_alignment_score_fill_core.sv]
// channel | handshake                 | payload | moves
// item    | item_valid / item_stall   | item    | top load or side symbol
// result  | result_valid/result_stall | result  | score, branch count, overflow
// cfg     | cfg_we                    | cfg_data| register write at cfg_index
//
// Side symbol: ST_BOUND, ST_SETUP, then ST_FILL one cell at a time through the
// shared cell unit, limited by the single score RAM read/write pair; a side
// symbol past MAX_SIDE_LEN sets the overflow flag and fills no row. A last side
// symbol goes to ST_RESULT to move the result into the output register.
// Reset (rst, synchronous) clears the sequencer and counters and sets the
// configuration registers to 1; the RAMs need no clearing. item_stall is high
// while an item is in progress or a result waits for a full output register.
module global_alignment_score_fill_core #(
  parameter int MAX_TOP_LEN  = gasf_pkg::MAX_TOP_LEN_DEF,
  parameter int MAX_SIDE_LEN = gasf_pkg::MAX_SIDE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gasf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gasf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  gasf_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output gasf_pkg::result_t                result
);

  localparam int LEN_W  = $clog2(MAX_TOP_LEN + 1);
  localparam int TA_W   = (MAX_TOP_LEN > 1) ? $clog2(MAX_TOP_LEN) : 1;
  localparam int ROW_W  = $clog2(MAX_SIDE_LEN + 1);
  localparam int PROD_W = ROW_W + gasf_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_SETUP,
    ST_FILL,
    ST_RESULT
  } state_t;

  state_t state;

  logic [gasf_pkg::CFG_W-1:0] match_bonus;
  logic [gasf_pkg::CFG_W-1:0] mismatch_cost;
  logic [gasf_pkg::CFG_W-1:0] gap_cost;

  logic [LEN_W-1:0]          top_length;
  logic [ROW_W-1:0]          row_index;
  gasf_pkg::branch_t         branch_total;
  logic                      overflow_seen;
  logic [LEN_W-1:0]          col;
  logic [gasf_pkg::SYM_W-1:0] side_sym;
  logic                      side_last;
  logic [PROD_W-1:0]         prod;
  gasf_pkg::score_t          diag;
  gasf_pkg::score_t          left;
  gasf_pkg::score_t          up0;

  logic                      item_accept;
  logic                      res_load;
  logic [31:0]               prod_ext;
  gasf_pkg::score_t          left_bnd;
  gasf_pkg::score_t          up_src;
  logic [LEN_W-1:0]          col_inc;

  logic                       top_we;
  logic [TA_W-1:0]            top_waddr;
  logic [TA_W-1:0]            top_raddr;
  logic [gasf_pkg::SYM_W-1:0] top_rdata;

  logic                       score_we;
  logic [LEN_W-1:0]           score_waddr;
  gasf_pkg::score_t           score_wdata;
  logic [LEN_W-1:0]           score_raddr;
  logic [gasf_pkg::SCORE_W-1:0] score_rdata;

  gasf_pkg::cell_in_t  cell_in;
  gasf_pkg::cell_out_t cell_out;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign res_load    = (state == ST_RESULT) && (!result_valid || !result_stall);
  assign col_inc     = col + LEN_W'(1);

  // boundary cell of the current row: saturated -(row + 1) * gap cost
  assign prod_ext = 32'(prod);
  assign left_bnd = (prod_ext > 32'(gasf_pkg::SCORE_MIN_MAG)) ? gasf_pkg::ScoreMin
                  : gasf_pkg::score_t'(32'd0 - prod_ext);

  // the first row reads its upper neighbor from the boundary row
  assign up_src = (row_index == '0) ? up0 : gasf_pkg::score_t'(score_rdata);

  always_comb begin
    cell_in.diag     = diag;
    cell_in.up       = up_src;
    cell_in.left     = left;
    cell_in.is_match = (top_rdata == side_sym);
    cell_in.bonus    = match_bonus;
    cell_in.mismatch = mismatch_cost;
    cell_in.indel    = gap_cost;
  end

  gasf_cell u_cell (
    .cell_in  (cell_in),
    .cell_out (cell_out)
  );

  always_comb begin
    top_we      = 1'b0;
    top_waddr   = TA_W'(top_length);
    top_raddr   = TA_W'(col);
    score_we    = 1'b0;
    score_waddr = col;
    score_wdata = cell_out.best;
    score_raddr = col_inc;
    case (state)
      ST_IDLE: begin
        top_we = item_accept && (item.cmd == gasf_pkg::CMD_LOAD_TOP)
              && (row_index == '0) && (top_length < LEN_W'(MAX_TOP_LEN));
      end
      ST_BOUND: begin
        score_raddr = '0;
      end
      ST_SETUP: begin
        score_we    = 1'b1;
        score_waddr = '0;
        score_wdata = left_bnd;
        score_raddr = LEN_W'(1);
        top_raddr   = '0;
      end
      ST_FILL: begin
        score_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gasf_ram #(
    .WIDTH (gasf_pkg::SYM_W),
    .DEPTH (MAX_TOP_LEN)
  ) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (item.symbol),
    .raddr (top_raddr),
    .rdata (top_rdata)
  );

  gasf_ram #(
    .WIDTH (gasf_pkg::SCORE_W),
    .DEPTH (MAX_TOP_LEN + 1)
  ) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (score_wdata),
    .raddr (score_raddr),
    .rdata (score_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      match_bonus      <= gasf_pkg::CFG_W'(1);
      mismatch_cost    <= gasf_pkg::CFG_W'(1);
      gap_cost         <= gasf_pkg::CFG_W'(1);
      top_length       <= '0;
      row_index        <= '0;
      branch_total     <= '0;
      overflow_seen    <= 1'b0;
      col              <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gasf_pkg::REG_MATCH:    match_bonus   <= cfg_data;
          gasf_pkg::REG_MISMATCH: mismatch_cost <= cfg_data;
          gasf_pkg::REG_INDEL:    gap_cost      <= cfg_data;
          default: begin
          end
        endcase
      end

      if (result_valid && !result_stall && !res_load) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            if (item.cmd == gasf_pkg::CMD_LOAD_TOP) begin
              if (row_index == '0) begin
                if (top_length < LEN_W'(MAX_TOP_LEN)) begin
                  top_length <= top_length + LEN_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
            end else begin
              side_sym  <= item.symbol;
              side_last <= item.last;
              if (row_index < ROW_W'(MAX_SIDE_LEN)) begin
                state <= ST_BOUND;
              end else begin
                overflow_seen <= 1'b1;
                if (item.last) begin
                  state <= ST_RESULT;
                end
              end
            end
          end
        end

        ST_BOUND: begin
          prod  <= PROD_W'(row_index + ROW_W'(1)) * PROD_W'(gap_cost);
          state <= ST_SETUP;
        end

        ST_SETUP: begin
          left <= left_bnd;
          diag <= (row_index == '0) ? '0 : gasf_pkg::score_t'(score_rdata);
          up0  <= gasf_pkg::score_t'(0) - gasf_pkg::score_t'({1'b0, gap_cost});
          col  <= LEN_W'(1);
          if (top_length == '0) begin
            row_index <= row_index + ROW_W'(1);
            state     <= side_last ? ST_RESULT : ST_IDLE;
          end else begin
            state <= ST_FILL;
          end
        end

        ST_FILL: begin
          left <= cell_out.best;
          diag <= up_src;
          up0  <= gasf_pkg::sat_score(gasf_pkg::ext_t'(up0)
                                      - gasf_pkg::ext_t'({1'b0, gap_cost}));
          if (cell_out.branch && (branch_total != gasf_pkg::BranchMax)) begin
            branch_total <= branch_total + gasf_pkg::branch_t'(1);
          end
          if (col == top_length) begin
            row_index <= row_index + ROW_W'(1);
            state     <= side_last ? ST_RESULT : ST_IDLE;
          end else begin
            col <= col_inc;
          end
        end

        ST_RESULT: begin
          if (res_load) begin
            result_valid           <= 1'b1;
            result.final_score     <= left;
            result.branch_count    <= branch_total;
            result.length_overflow <= overflow_seen;
            top_length             <= '0;
            row_index              <= '0;
            branch_total           <= '0;
            overflow_seen          <= 1'b0;
            state                  <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_top_len_bound: assert property (@(posedge clk) disable iff (rst)
    top_length <= LEN_W'(MAX_TOP_LEN))
    else $error("top length beyond maximum");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_index <= ROW_W'(MAX_SIDE_LEN))
    else $error("row index beyond maximum");

  a_fill_col: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> ((col != '0) && (col <= top_length)))
    else $error("fill column out of range");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (result_valid && (row_index == '0) && (top_length == '0)
                  && (branch_total == '0) && !overflow_seen))
    else $error("pair state not cleared after result");

  a_top_frozen_in_fill: assert property (@(posedge clk) disable iff (rst)
    ((row_index != '0) && !res_load) |=> $stable(top_length))
    else $error("top length changed during fill");
`endif

endmodule

[rtl/core/gasf_ram.sv]
module gasf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/gasf_cell.sv]
module gasf_cell (
  input  gasf_pkg::cell_in_t  cell_in,
  output gasf_pkg::cell_out_t cell_out
);

  gasf_pkg::score_t c_diag;
  gasf_pkg::score_t c_up;
  gasf_pkg::score_t c_left;
  gasf_pkg::score_t gap_best;
  gasf_pkg::score_t best;

  always_comb begin
    if (cell_in.is_match) begin
      c_diag = gasf_pkg::sat_score(gasf_pkg::ext_t'(cell_in.diag)
                                   + gasf_pkg::ext_t'({1'b0, cell_in.bonus}));
    end else begin
      c_diag = gasf_pkg::sat_score(gasf_pkg::ext_t'(cell_in.diag)
                                   - gasf_pkg::ext_t'({1'b0, cell_in.mismatch}));
    end
    c_up   = gasf_pkg::sat_score(gasf_pkg::ext_t'(cell_in.up)
                                 - gasf_pkg::ext_t'({1'b0, cell_in.indel}));
    c_left = gasf_pkg::sat_score(gasf_pkg::ext_t'(cell_in.left)
                                 - gasf_pkg::ext_t'({1'b0, cell_in.indel}));

    gap_best = (c_left > c_up) ? c_left : c_up;
    best     = (c_diag > gap_best) ? c_diag : gap_best;

    cell_out.best   = best;
    // two or more candidates reach the maximum
    cell_out.branch = ((c_diag == best) && (c_up == best))
                   || ((c_diag == best) && (c_left == best))
                   || ((c_up == best) && (c_left == best));
  end

endmodule
